// File: hw/rtl/tpcd_pkg.sv
package tpcd_pkg;

    // Pattern cell fields as they arrive
    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
    } cell_item_t;

    // Decoded fields
    typedef struct packed {
        logic [7:0] instrument_number;
        logic [6:0] note_number;
        logic [3:0] effect_command;
        logic [7:0] effect_value;
    } field_item_t;

    localparam int unsigned PERIOD_W   = 12;
    localparam int unsigned NOTE_W     = 7;
    localparam int unsigned BOUND_CNT  = 1 << NOTE_W;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(14);

    // Largest period that still rounds to note n+1 or higher. Bounds above the
    // 12-bit period range are clipped to its top, which compares the same way;
    // entries past the last note are zero so they never match.
    localparam logic [PERIOD_W-1:0] NOTE_BOUND [BOUND_CNT] = '{
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd3955, 12'd3733,
        12'd3524, 12'd3326, 12'd3139, 12'd2963, 12'd2797, 12'd2640,
        12'd2492, 12'd2352, 12'd2220, 12'd2095, 12'd1977, 12'd1866,
        12'd1762, 12'd1663, 12'd1569, 12'd1481, 12'd1398, 12'd1320,
        12'd1246, 12'd1176, 12'd1110, 12'd1047, 12'd988,  12'd933,
        12'd881,  12'd831,  12'd784,  12'd740,  12'd699,  12'd660,
        12'd623,  12'd588,  12'd555,  12'd523,  12'd494,  12'd466,
        12'd440,  12'd415,  12'd392,  12'd370,  12'd349,  12'd330,
        12'd311,  12'd294,  12'd277,  12'd261,  12'd247,  12'd233,
        12'd220,  12'd207,  12'd196,  12'd185,  12'd174,  12'd165,
        12'd155,  12'd147,  12'd138,  12'd130,  12'd123,  12'd116,
        12'd110,  12'd103,  12'd98,   12'd92,   12'd87,   12'd82,
        12'd77,   12'd73,   12'd69,   12'd65,   12'd61,   12'd58,
        12'd55,   12'd51,   12'd49,   12'd46,   12'd43,   12'd41,
        12'd38,   12'd36,   12'd34,   12'd32,   12'd30,   12'd29,
        12'd27,   12'd25,   12'd24,   12'd23,   12'd21,   12'd20,
        12'd19,   12'd18,   12'd17,   12'd16,   12'd15,   12'd14,
        12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
        12'd0,    12'd0
    };

    // Work carried between pipeline stages
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                small_period;
        logic [NOTE_W-1:0]   note_count;
        logic [7:0]          instrument_number;
        logic [3:0]          effect_command;
        logic [7:0]          effect_value;
    } stage_t;

    // One binary search step: try setting count bit bit_pos
    function automatic logic [NOTE_W-1:0] search_step(
        input logic [PERIOD_W-1:0] period,
        input logic [NOTE_W-1:0]   count,
        input logic [2:0]          bit_pos
    );
        logic [NOTE_W-1:0] trial;
        logic [NOTE_W-1:0] idx;
        trial = count | (NOTE_W'(1) << bit_pos);
        idx   = trial - NOTE_W'(1);
        if (period <= NOTE_BOUND[idx])
            return trial;
        else
            return count;
    endfunction

endpackage

// File: hw/rtl/tracker_pattern_cell_decoder_top.sv
// Pattern cell decoder: takes one four-byte tracker cell per cycle while not
// stalled and returns instrument, note, effect command and effect parameter.
// The 12-bit period is mapped to the nearest note 1..120 by a seven-step
// binary search over a constant table of period bounds, split over three
// register stages (two, two and three steps); periods below 14 give note 0.
// The work is registered in s1_reg, s2_reg and s3_reg in turn; s3_reg is the
// output register. Output stall freezes the whole pipeline at once, so
// cell_stall follows field_stall while a result is waiting.
module tracker_pattern_cell_decoder_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cell_valid,
    output logic                   cell_stall,
    input  tpcd_pkg::cell_item_t   cell_item,
    output logic                   field_valid,
    input  logic                   field_stall,
    output tpcd_pkg::field_item_t  field_item
);
    import tpcd_pkg::*;

    logic        advance;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    stage_t      s1_reg, s1_next;
    stage_t      s2_reg, s2_next;
    field_item_t s3_reg, s3_next;
    logic        s3_small_reg;

    // Move all stages together unless a finished item waits on the output
    assign advance    = !(s3_valid_reg && field_stall);
    assign cell_stall = !advance;

    // Stage 1: unpack fields, first two search steps
    always_comb
    begin
        s1_next.period            = {cell_item.byte_zero[3:0], cell_item.byte_one};
        s1_next.small_period      = s1_next.period < MIN_PERIOD;
        s1_next.instrument_number = {cell_item.byte_zero[7:4], cell_item.byte_two[7:4]};
        s1_next.effect_command    = cell_item.byte_two[3:0];
        s1_next.effect_value      = cell_item.byte_three;
        s1_next.note_count        = search_step(s1_next.period, '0, 3'd6);
        s1_next.note_count        = search_step(s1_next.period, s1_next.note_count, 3'd5);
    end

    // Stage 2: next two search steps
    always_comb
    begin
        s2_next            = s1_reg;
        s2_next.note_count = search_step(s1_reg.period, s1_reg.note_count, 3'd4);
        s2_next.note_count = search_step(s1_reg.period, s2_next.note_count, 3'd3);
    end

    // Stage 3: last three steps, drop the note for small periods
    always_comb
    begin
        logic [NOTE_W-1:0] cnt;
        cnt = search_step(s2_reg.period, s2_reg.note_count, 3'd2);
        cnt = search_step(s2_reg.period, cnt, 3'd1);
        cnt = search_step(s2_reg.period, cnt, 3'd0);
        s3_next.instrument_number = s2_reg.instrument_number;
        s3_next.note_number       = s2_reg.small_period ? '0 : cnt;
        s3_next.effect_command    = s2_reg.effect_command;
        s3_next.effect_value      = s2_reg.effect_value;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= cell_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            s3_small_reg <= s2_reg.small_period;
        end
    end

    assign field_valid = s3_valid_reg;
    assign field_item  = s3_reg;

    // Note stays inside its range
    assert property (@(posedge clk) disable iff (!rst_n)
        field_valid |-> field_item.note_number <= NOTE_W'(120))
        else $error("note number out of range");

    // Small period gives no note
    assert property (@(posedge clk) disable iff (!rst_n)
        (field_valid && s3_small_reg) |-> field_item.note_number == '0)
        else $error("note given for small period");

    // Any other period gives a note
    assert property (@(posedge clk) disable iff (!rst_n)
        (field_valid && !s3_small_reg) |-> field_item.note_number != '0)
        else $error("note missing for valid period");

    // An accepted item reaches the output if the pipeline keeps advancing
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall) ##1 !cell_stall ##1 !cell_stall |=> field_valid)
        else $error("item lost in pipeline");

endmodule
